### design/ids_pkg.sv
// Shared constants, types and helpers for the image difference statistics block.
`default_nettype none
package ids_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COUNT_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int NUM_LIMITS_DEF = 4;

  localparam int PIX_W      = 24;
  localparam int ABS_W      = 25;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int LUMA_W     = 26;
  localparam int STAT_W     = 64;
  localparam int CODE_W     = 6;
  localparam int NUM_STATS  = 37;
  localparam int LIMIT_REGS = 4;
  localparam int LIMIT_W    = 26;
  localparam int WIDTH_W    = 13;
  localparam int THR_W      = 23;
  localparam int TCNT_W     = 3;
  localparam int CFG_W      = 26;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CODE_W-1:0] STAT_LAST = CODE_W'(NUM_STATS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_LITTHR = 3'd1,
    CFG_TCOUNT = 3'd2,
    CFG_LIM_A  = 3'd3,
    CFG_LIM_B  = 3'd4,
    CFG_LIM_C  = 3'd5,
    CFG_LIM_D  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]                   width;
    logic [THR_W-1:0]                     lit_thr;
    logic [TCNT_W-1:0]                    tcount;
    logic [LIMIT_REGS-1:0][LIMIT_W-1:0]   limits;
  } cfg_t;

  function automatic logic signed [STAT_W-1:0] add_sat_s64(
    input logic signed [STAT_W-1:0] a,
    input logic signed [STAT_W-1:0] b
  );
    logic signed [STAT_W-1:0] s;
    s = a + b;
    if (a[STAT_W-1] == b[STAT_W-1] && s[STAT_W-1] != a[STAT_W-1]) begin
      s = a[STAT_W-1] ? {1'b1, {(STAT_W-1){1'b0}}} : {1'b0, {(STAT_W-1){1'b1}}};
    end
    return s;
  endfunction

endpackage
`default_nettype wire

### design/ids_pix_if.sv
// Pixel pair request channel.
`default_nettype none
interface ids_pix_if
  import ids_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] ref_red;
  logic signed [PIX_W-1:0] ref_green;
  logic signed [PIX_W-1:0] ref_blue;
  logic signed [PIX_W-1:0] cand_red;
  logic signed [PIX_W-1:0] cand_green;
  logic signed [PIX_W-1:0] cand_blue;
  logic                    last_pixel;

  modport source (output valid, ref_red, ref_green, ref_blue, cand_red, cand_green,
                  cand_blue, last_pixel, input ready);
  modport sink (input valid, ref_red, ref_green, ref_blue, cand_red, cand_green,
                cand_blue, last_pixel, output ready);
endinterface
`default_nettype wire

### design/ids_stat_if.sv
// Statistic result request channel.
`default_nettype none
interface ids_stat_if
  import ids_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CODE_W-1:0]        stat_code;
  logic signed [STAT_W-1:0] stat_value;
  logic                     last_stat;

  modport source (output valid, stat_code, stat_value, last_stat, input ready);
  modport sink (input valid, stat_code, stat_value, last_stat, output ready);
endinterface
`default_nettype wire

### design/ids_chan_lane.sv
// One color channel lane: absolute error, then its square.
`default_nettype none
module ids_chan_lane
  import ids_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic signed [PIX_W-1:0] ref_i,
  input  wire logic signed [PIX_W-1:0] cand_i,
  output logic [ABS_W-1:0]             abs_o,
  output logic [SQ_W-1:0]              sq_o
);
  logic signed [ABS_W-1:0] diff;
  logic [ABS_W-1:0]        abs1_q, abs2_q;
  logic [SQ_W-1:0]         sq2_q;

  assign diff = ABS_W'(cand_i) - ABS_W'(ref_i);

  always_ff @(posedge clk_i) begin
    abs1_q <= diff[ABS_W-1] ? ABS_W'(-diff) : ABS_W'(diff);
    abs2_q <= abs1_q;
    sq2_q  <= abs1_q * abs1_q;
  end

  assign abs_o = abs2_q;
  assign sq_o  = sq2_q;
endmodule
`default_nettype wire

### design/ids_luma_lane.sv
// Rec.709 luminance lane: weighted products, then rounded sum.
`default_nettype none
module ids_luma_lane
  import ids_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic signed [PIX_W-1:0] red_i,
  input  wire logic signed [PIX_W-1:0] green_i,
  input  wire logic signed [PIX_W-1:0] blue_i,
  output logic signed [LUMA_W-1:0]     luma_o
);
  localparam longint WR_L = ((longint'(2126) << FRAC_BITS) + 64'sd5000) / 64'sd10000;
  localparam longint WG_L = ((longint'(7152) << FRAC_BITS) + 64'sd5000) / 64'sd10000;
  localparam longint WB_L = ((longint'(722) << FRAC_BITS) + 64'sd5000) / 64'sd10000;
  localparam int WT_W = FRAC_BITS + 2;
  localparam int PR_W = PIX_W + WT_W;
  localparam int SM_W = PR_W + 2;
  localparam logic signed [WT_W-1:0] WR = WT_W'(WR_L);
  localparam logic signed [WT_W-1:0] WG = WT_W'(WG_L);
  localparam logic signed [WT_W-1:0] WB = WT_W'(WB_L);
  localparam logic signed [SM_W-1:0] HALF = SM_W'(longint'(1) << (FRAC_BITS - 1));

  logic signed [PR_W-1:0]   pr_q, pg_q, pb_q;
  logic signed [SM_W-1:0]   sum;
  logic signed [SM_W-1:0]   shifted;
  logic signed [LUMA_W-1:0] luma_q;

  assign sum     = SM_W'(pr_q) + SM_W'(pg_q) + SM_W'(pb_q) + HALF;
  assign shifted = sum >>> FRAC_BITS;

  always_ff @(posedge clk_i) begin
    pr_q   <= PR_W'(red_i) * PR_W'(WR);
    pg_q   <= PR_W'(green_i) * PR_W'(WG);
    pb_q   <= PR_W'(blue_i) * PR_W'(WB);
    luma_q <= LUMA_W'(shifted);
  end

  assign luma_o = luma_q;
endmodule
`default_nettype wire

### design/ids_accum.sv
// Merge stage: folds lane results into the image accumulators and builds the report.
`default_nettype none
module ids_accum
  import ids_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int NUM_LIMITS = NUM_LIMITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire cfg_t                              cfg_i,
  input  wire logic                              valid_i,
  input  wire logic                              last_i,
  input  wire logic [COORD_BITS-1:0]             x_i,
  input  wire logic [COORD_BITS-1:0]             y_i,
  input  wire logic [2:0][ABS_W-1:0]             abs_i,
  input  wire logic [2:0][SQ_W-1:0]              sq_i,
  input  wire logic [5:0][PIX_W-1:0]             pix_i,
  input  wire logic signed [LUMA_W-1:0]          luma_ref_i,
  input  wire logic signed [LUMA_W-1:0]          luma_cand_i,
  output logic                                   snap_o,
  output logic [NUM_STATS-1:0][STAT_W-1:0]       stats_o
);
  localparam int CS_W = COORD_BITS + COUNT_BITS;

  logic signed [STAT_W-1:0] abs_sum_q, abs_sum_d, sq_sum_q, sq_sum_d;
  logic [ABS_W-1:0]         max_err_q, max_err_d;
  logic [COORD_BITS-1:0]    wx_q, wx_d, wy_q, wy_d;
  logic [1:0]               wch_q, wch_d;
  logic [5:0][PIX_W-1:0]    wpix_q, wpix_d;
  logic [1:0][STAT_W-1:0]   lsum_q, lsum_d;
  logic [1:0][LUMA_W-1:0]   lmax_q, lmax_d;
  logic [1:0][COUNT_BITS-1:0] lit_q, lit_d, one_q, one_d;
  logic [7:0][COORD_BITS-1:0] box_q, box_d;
  logic [3:0][CS_W-1:0]     cs_q, cs_d;
  logic [LIMIT_REGS-1:0][COUNT_BITS-1:0] sim_q, sim_d;
  logic [COUNT_BITS-1:0]    tot_q, tot_d;

  logic [ABS_W+1:0]         l1;
  logic [SQ_W+1:0]          sq3;
  logic [ABS_W-1:0]         best;
  logic [1:0]               best_ch;
  logic [1:0]               lit;
  logic [1:0][LUMA_W-1:0]   luma;
  logic signed [LUMA_W-1:0] thr;
  logic [CS_W:0]            cs_x, cs_y;

  assign luma[0] = luma_ref_i;
  assign luma[1] = luma_cand_i;
  assign thr     = $signed({{(LUMA_W-THR_W){1'b0}}, cfg_i.lit_thr});

  always_comb begin
    abs_sum_d = abs_sum_q;
    sq_sum_d  = sq_sum_q;
    max_err_d = max_err_q;
    wx_d      = wx_q;
    wy_d      = wy_q;
    wch_d     = wch_q;
    wpix_d    = wpix_q;
    lsum_d    = lsum_q;
    lmax_d    = lmax_q;
    lit_d     = lit_q;
    one_d     = one_q;
    box_d     = box_q;
    cs_d      = cs_q;
    sim_d     = sim_q;
    tot_d     = tot_q;
    l1        = (ABS_W+2)'(abs_i[0]) + (ABS_W+2)'(abs_i[1]) + (ABS_W+2)'(abs_i[2]);
    sq3       = (SQ_W+2)'(sq_i[0]) + (SQ_W+2)'(sq_i[1]) + (SQ_W+2)'(sq_i[2]);
    best      = abs_i[0];
    best_ch   = 2'd0;
    lit       = '0;
    cs_x      = '0;
    cs_y      = '0;
    if (abs_i[1] > best) begin
      best    = abs_i[1];
      best_ch = 2'd1;
    end
    if (abs_i[2] > best) begin
      best    = abs_i[2];
      best_ch = 2'd2;
    end
    if (valid_i) begin
      abs_sum_d = add_sat_s64(abs_sum_q, STAT_W'(l1));
      sq_sum_d  = add_sat_s64(sq_sum_q, STAT_W'(sq3));
      if (best > max_err_q) begin
        max_err_d = best;
        wx_d      = x_i;
        wy_d      = y_i;
        wch_d     = best_ch;
        wpix_d    = pix_i;
      end
      for (int s = 0; s < 2; s++) begin
        lsum_d[s] = add_sat_s64(lsum_q[s], STAT_W'($signed(luma[s])));
        if ($signed(luma[s]) > $signed(lmax_q[s])) lmax_d[s] = luma[s];
        lit[s] = $signed(luma[s]) > thr;
        if (lit[s]) begin
          if (lit_q[s] == '0) begin
            box_d[4*s]   = x_i;
            box_d[4*s+1] = y_i;
            box_d[4*s+2] = x_i;
            box_d[4*s+3] = y_i;
          end else begin
            if (x_i < box_q[4*s])   box_d[4*s]   = x_i;
            if (y_i < box_q[4*s+1]) box_d[4*s+1] = y_i;
            if (x_i > box_q[4*s+2]) box_d[4*s+2] = x_i;
            if (y_i > box_q[4*s+3]) box_d[4*s+3] = y_i;
          end
          if (lit_q[s] != '1) lit_d[s] = lit_q[s] + 1'b1;
          cs_x = {1'b0, cs_q[2*s]} + (CS_W+1)'(x_i);
          cs_y = {1'b0, cs_q[2*s+1]} + (CS_W+1)'(y_i);
          cs_d[2*s]   = cs_x[CS_W] ? '1 : cs_x[CS_W-1:0];
          cs_d[2*s+1] = cs_y[CS_W] ? '1 : cs_y[CS_W-1:0];
        end
      end
      // one-sided lit counts
      if (lit[0] && !lit[1] && one_q[0] != '1) one_d[0] = one_q[0] + 1'b1;
      if (lit[1] && !lit[0] && one_q[1] != '1) one_d[1] = one_q[1] + 1'b1;
      for (int i = 0; i < LIMIT_REGS; i++) begin
        if (i < NUM_LIMITS && int'(cfg_i.tcount) > i &&
            l1 <= (ABS_W+2)'(cfg_i.limits[i]) && sim_q[i] != '1) begin
          sim_d[i] = sim_q[i] + 1'b1;
        end
      end
      if (tot_q != '1) tot_d = tot_q + 1'b1;
    end
  end

  assign snap_o = valid_i && last_i;

  always_comb begin
    stats_o[0]  = STAT_W'(tot_d);
    stats_o[1]  = abs_sum_d;
    stats_o[2]  = sq_sum_d;
    stats_o[3]  = STAT_W'(max_err_d);
    stats_o[4]  = STAT_W'(wx_d);
    stats_o[5]  = STAT_W'(wy_d);
    stats_o[6]  = STAT_W'(wch_d);
    for (int i = 0; i < 6; i++) stats_o[7+i] = STAT_W'($signed(wpix_d[i]));
    stats_o[13] = lsum_d[0];
    stats_o[14] = lsum_d[1];
    stats_o[15] = STAT_W'($signed(lmax_d[0]));
    stats_o[16] = STAT_W'($signed(lmax_d[1]));
    stats_o[17] = STAT_W'(lit_d[0]);
    stats_o[18] = STAT_W'(lit_d[1]);
    for (int i = 0; i < 8; i++) stats_o[19+i] = STAT_W'(box_d[i]);
    for (int i = 0; i < 4; i++) stats_o[27+i] = STAT_W'(cs_d[i]);
    stats_o[31] = STAT_W'(one_d[0]);
    stats_o[32] = STAT_W'(one_d[1]);
    for (int i = 0; i < LIMIT_REGS; i++) stats_o[33+i] = STAT_W'(sim_d[i]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_sum_q <= '0;
      sq_sum_q  <= '0;
      max_err_q <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
      wch_q     <= '0;
      wpix_q    <= '0;
      lsum_q    <= '0;
      lmax_q    <= '0;
      lit_q     <= '0;
      one_q     <= '0;
      box_q     <= '0;
      cs_q      <= '0;
      sim_q     <= '0;
      tot_q     <= '0;
    end else if (snap_o) begin
      // drop the finished image once its report is taken
      abs_sum_q <= '0;
      sq_sum_q  <= '0;
      max_err_q <= '0;
      wx_q      <= '0;
      wy_q      <= '0;
      wch_q     <= '0;
      wpix_q    <= '0;
      lsum_q    <= '0;
      lmax_q    <= '0;
      lit_q     <= '0;
      one_q     <= '0;
      box_q     <= '0;
      cs_q      <= '0;
      sim_q     <= '0;
      tot_q     <= '0;
    end else begin
      abs_sum_q <= abs_sum_d;
      sq_sum_q  <= sq_sum_d;
      max_err_q <= max_err_d;
      wx_q      <= wx_d;
      wy_q      <= wy_d;
      wch_q     <= wch_d;
      wpix_q    <= wpix_d;
      lsum_q    <= lsum_d;
      lmax_q    <= lmax_d;
      lit_q     <= lit_d;
      one_q     <= one_d;
      box_q     <= box_d;
      cs_q      <= cs_d;
      sim_q     <= sim_d;
      tot_q     <= tot_d;
    end
  end

  // a lit bounding box never inverts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q[0] != '0 |-> box_q[0] <= box_q[2] && box_q[1] <= box_q[3])
    else $error("reference lit box inverted");
  // no lit pixel means no coordinate sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_q[1] == '0 |-> cs_q[2] == '0 && cs_q[3] == '0)
    else $error("candidate coordinate sum without lit pixel");
  // the worst channel error is bounded by the absolute sum while no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_err_q != '0 |-> abs_sum_q >= STAT_W'(max_err_q))
    else $error("worst error exceeds absolute sum");
endmodule
`default_nettype wire

### design/image_difference_statistics.sv
// Top level: pixel coordinates, lane pipeline, merge stage and report serializer.
//
//  channel   dir  handshake            payload
//  pix_i     in   valid/ready          ref/cand RGB (Q8.16), last_pixel
//  stat_o    out  valid/ready          stat_code, stat_value, last_stat
//  cfg       in   cfg_we_i             cfg_idx_i, cfg_data_i
//
// One pixel pair per cycle unless a last pixel is held (see below); lane registers feed the merge stage.
// The last pixel loads a 37-entry report shift line, drained one statistic
// per accepted output cycle while the next image keeps streaming in.
// A new last pixel waits only while a report is still draining or in flight.
// Reset clears all accumulators, the coordinates and the report state.
`default_nettype none
module image_difference_statistics
  import ids_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int NUM_LIMITS = NUM_LIMITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  ids_pix_if.sink                   pix_i,
  ids_stat_if.source                stat_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);
  localparam int WW = (COORD_BITS + 1 > WIDTH_W) ? COORD_BITS + 1 : WIDTH_W;
  localparam logic [WW-1:0] W_LIM = WW'(1) << COORD_BITS;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width   <= WIDTH_W'(1);
      cfg_q.lit_thr <= THR_W'(7);
      cfg_q.tcount  <= '0;
      cfg_q.limits  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  cfg_q.width     <= cfg_data_i[WIDTH_W-1:0];
        CFG_LITTHR: cfg_q.lit_thr   <= cfg_data_i[THR_W-1:0];
        CFG_TCOUNT: cfg_q.tcount    <= cfg_data_i[TCNT_W-1:0];
        CFG_LIM_A:  cfg_q.limits[0] <= cfg_data_i[LIMIT_W-1:0];
        CFG_LIM_B:  cfg_q.limits[1] <= cfg_data_i[LIMIT_W-1:0];
        CFG_LIM_C:  cfg_q.limits[2] <= cfg_data_i[LIMIT_W-1:0];
        CFG_LIM_D:  cfg_q.limits[3] <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  logic busy_q;
  logic v1_q, v2_q, l1_q, l2_q;
  logic [COORD_BITS-1:0] x_q, y_q, x1_q, y1_q, x2_q, y2_q;
  logic [5:0][PIX_W-1:0] pix0, pix1_q, pix2_q;
  logic [WW-1:0] wide, weff, xn;

  // hold a last pixel while an earlier report is still pending
  assign pix_i.ready = !(pix_i.last_pixel && (busy_q || (v1_q && l1_q) || (v2_q && l2_q)));
  assign accept      = pix_i.valid && pix_i.ready;

  assign pix0 = {pix_i.cand_blue, pix_i.cand_green, pix_i.cand_red,
                 pix_i.ref_blue, pix_i.ref_green, pix_i.ref_red};

  assign wide = WW'(cfg_q.width);
  assign xn   = WW'(x_q) + WW'(1);

  always_comb begin
    if (wide == '0)        weff = WW'(1);
    else if (wide > W_LIM) weff = W_LIM;
    else                   weff = wide;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q  <= '0;
      y_q  <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      l1_q <= 1'b0;
      l2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      l1_q <= pix_i.last_pixel;
      l2_q <= l1_q;
      if (accept) begin
        if (pix_i.last_pixel) begin
          x_q <= '0;
          y_q <= '0;
        end else if (xn >= weff) begin
          x_q <= '0;
          if (y_q != '1) y_q <= y_q + 1'b1;
        end else begin
          x_q <= COORD_BITS'(xn);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q   <= x_q;
    y1_q   <= y_q;
    x2_q   <= x1_q;
    y2_q   <= y1_q;
    pix1_q <= pix0;
    pix2_q <= pix1_q;
  end

  logic [2:0][ABS_W-1:0]    abs2;
  logic [2:0][SQ_W-1:0]     sq2;
  logic signed [LUMA_W-1:0] luma_ref, luma_cand;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    ids_chan_lane u_chan (
      .clk_i  (clk_i),
      .ref_i  ($signed(pix0[c])),
      .cand_i ($signed(pix0[c+3])),
      .abs_o  (abs2[c]),
      .sq_o   (sq2[c])
    );
  end

  ids_luma_lane #(.FRAC_BITS(FRAC_BITS)) u_luma_ref (
    .clk_i   (clk_i),
    .red_i   (pix_i.ref_red),
    .green_i (pix_i.ref_green),
    .blue_i  (pix_i.ref_blue),
    .luma_o  (luma_ref)
  );

  ids_luma_lane #(.FRAC_BITS(FRAC_BITS)) u_luma_cand (
    .clk_i   (clk_i),
    .red_i   (pix_i.cand_red),
    .green_i (pix_i.cand_green),
    .blue_i  (pix_i.cand_blue),
    .luma_o  (luma_cand)
  );

  logic                              snap;
  logic [NUM_STATS-1:0][STAT_W-1:0]  stats;

  ids_accum #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS),
    .NUM_LIMITS (NUM_LIMITS)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (v2_q),
    .last_i      (l2_q),
    .x_i         (x2_q),
    .y_i         (y2_q),
    .abs_i       (abs2),
    .sq_i        (sq2),
    .pix_i       (pix2_q),
    .luma_ref_i  (luma_ref),
    .luma_cand_i (luma_cand),
    .snap_o      (snap),
    .stats_o     (stats)
  );

  logic [NUM_STATS-1:0][STAT_W-1:0] sr_q;
  logic [CODE_W-1:0]                step_q;
  logic                             pop;

  assign pop = busy_q && stat_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (snap) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (pop) begin
      if (step_q == STAT_LAST) begin
        busy_q <= 1'b0;
        step_q <= '0;
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // advance the report line one statistic per pop
  always_ff @(posedge clk_i) begin
    if (snap) begin
      sr_q <= stats;
    end else if (pop) begin
      for (int k = 0; k < NUM_STATS - 1; k++) sr_q[k] <= sr_q[k+1];
    end
  end

  assign stat_o.valid      = busy_q;
  assign stat_o.stat_code  = step_q;
  assign stat_o.stat_value = sr_q[0];
  assign stat_o.last_stat  = (step_q == STAT_LAST);

  assert property (@(posedge clk_i) disable iff (!rst_ni) snap |-> !busy_q)
    else $error("report loaded while draining");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap |=> busy_q && step_q == '0)
    else $error("report did not start at first statistic");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.valid && stat_o.ready && stat_o.last_stat |=> !busy_q)
    else $error("report continued past final statistic");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= STAT_LAST)
    else $error("report step out of range");
endmodule
`default_nettype wire

### sim/ids_checker.sv
// Checker: watches the pixel and statistic channels, predicts every report and compares.
`default_nettype none
module ids_checker
  import ids_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  ids_pix_if                        pix_mon,
  ids_stat_if                       stat_mon,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  output int                        fail_count_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Statistic numbering of one report
  localparam int ST_TOTAL     = 0;
  localparam int ST_ABS_SUM   = 1;
  localparam int ST_SQ_SUM    = 2;
  localparam int ST_MAX_ERR   = 3;
  localparam int ST_WORST_COL = 4;
  localparam int ST_WORST_ROW = 5;
  localparam int ST_WORST_CH  = 6;
  localparam int ST_WORST_PIX = 7;
  localparam int ST_LUMA_SUM  = 13;
  localparam int ST_LUMA_MAX  = 15;
  localparam int ST_LIT_CNT   = 17;
  localparam int ST_BOX       = 19;
  localparam int ST_CSUM      = 27;
  localparam int ST_ONE_SIDED = 31;
  localparam int ST_SIMILAR   = 33;

  localparam longint W_RED     = 13933;
  localparam longint W_GREEN   = 46871;
  localparam longint W_BLUE    = 4732;
  localparam longint CNT_CAP   = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam longint CSUM_CAP  = (64'd1 << (COORD_BITS_DEF + COUNT_BITS_DEF)) - 1;
  localparam longint COORD_TOP = (64'd1 << COORD_BITS_DEF) - 1;

  typedef struct {
    logic [CODE_W-1:0]        code;
    logic signed [STAT_W-1:0] value;
    logic                     last;
  } stat_t;

  stat_t  report_q[$];

  // Mirrored registers
  longint img_width, lit_thr, lim_used_cfg;
  longint sim_limit[LIMIT_REGS];

  // Accumulators
  longint abs_sum, sq_sum, max_err, worst_col, worst_row, worst_ch;
  longint worst_pix[6];
  longint luma_sum[2], luma_max[2], lit_cnt[2], one_sided[2];
  longint lit_box[8], coord_sum[4], sim_cnt[LIMIT_REGS];
  longint px_total, col, row;

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (b > 0 && s < a) s = 64'sh7FFF_FFFF_FFFF_FFFF;
    if (b < 0 && s > a) s = 64'sh8000_0000_0000_0000;
    return s;
  endfunction

  function automatic longint cap_add(longint a, longint b, longint cap);
    if (a >= cap || b > cap - a) return cap;
    return a + b;
  endfunction

  function automatic longint luma(longint r, longint g, longint b);
    return (W_RED * r + W_GREEN * g + W_BLUE * b + 32768) >>> 16;
  endfunction

  task automatic clear_image();
    abs_sum = 0; sq_sum = 0; max_err = 0;
    worst_col = 0; worst_row = 0; worst_ch = 0;
    foreach (worst_pix[i]) worst_pix[i] = 0;
    for (int s = 0; s < 2; s++) begin
      luma_sum[s] = 0; luma_max[s] = 0; lit_cnt[s] = 0; one_sided[s] = 0;
    end
    foreach (lit_box[i]) lit_box[i] = 0;
    foreach (coord_sum[i]) coord_sum[i] = 0;
    foreach (sim_cnt[i]) sim_cnt[i] = 0;
    px_total = 0; col = 0; row = 0;
  endtask

  task automatic mark_lit(int side);
    if (lit_cnt[side] == 0) begin
      lit_box[side*4] = col; lit_box[side*4+1] = row;
      lit_box[side*4+2] = col; lit_box[side*4+3] = row;
    end else begin
      if (col < lit_box[side*4]) lit_box[side*4] = col;
      if (row < lit_box[side*4+1]) lit_box[side*4+1] = row;
      if (col > lit_box[side*4+2]) lit_box[side*4+2] = col;
      if (row > lit_box[side*4+3]) lit_box[side*4+3] = row;
    end
    lit_cnt[side] = cap_add(lit_cnt[side], 1, CNT_CAP);
    coord_sum[side*2] = cap_add(coord_sum[side*2], col, CSUM_CAP);
    coord_sum[side*2+1] = cap_add(coord_sum[side*2+1], row, CSUM_CAP);
  endtask

  task automatic absorb_pixel();
    longint rp[3], cp[3];
    longint d, a, l1, lr, lc, used, w;
    longint v[NUM_STATS];
    stat_t  s;
    logic   rlit, clit;
    rp[0] = pix_mon.ref_red;  rp[1] = pix_mon.ref_green;  rp[2] = pix_mon.ref_blue;
    cp[0] = pix_mon.cand_red; cp[1] = pix_mon.cand_green; cp[2] = pix_mon.cand_blue;
    l1 = 0;
    for (int c = 0; c < 3; c++) begin
      d = cp[c] - rp[c];
      a = d < 0 ? -d : d;
      l1 += a;
      abs_sum = sat_add(abs_sum, a);
      sq_sum = sat_add(sq_sum, a * a);
      // strictly larger only, so the earlier channel keeps a tie
      if (a > max_err) begin
        max_err = a; worst_col = col; worst_row = row; worst_ch = c;
        for (int i = 0; i < 3; i++) begin
          worst_pix[i] = rp[i]; worst_pix[i+3] = cp[i];
        end
      end
    end
    lr = luma(rp[0], rp[1], rp[2]);
    lc = luma(cp[0], cp[1], cp[2]);
    luma_sum[0] = sat_add(luma_sum[0], lr);
    luma_sum[1] = sat_add(luma_sum[1], lc);
    if (lr > luma_max[0]) luma_max[0] = lr;
    if (lc > luma_max[1]) luma_max[1] = lc;
    rlit = lr > lit_thr;
    clit = lc > lit_thr;
    if (rlit) mark_lit(0);
    if (clit) mark_lit(1);
    if (rlit && !clit) one_sided[0] = cap_add(one_sided[0], 1, CNT_CAP);
    if (clit && !rlit) one_sided[1] = cap_add(one_sided[1], 1, CNT_CAP);
    used = lim_used_cfg > NUM_LIMITS_DEF ? NUM_LIMITS_DEF : lim_used_cfg;
    for (int i = 0; i < used; i++)
      if (l1 <= sim_limit[i]) sim_cnt[i] = cap_add(sim_cnt[i], 1, CNT_CAP);
    px_total = cap_add(px_total, 1, CNT_CAP);

    w = img_width == 0 ? 1 : img_width;
    if (w > COORD_TOP + 1) w = COORD_TOP + 1;
    if (col + 1 >= w) begin
      col = 0;
      if (row < COORD_TOP) row++;
    end else begin
      col++;
    end

    if (!pix_mon.last_pixel) return;
    v[ST_TOTAL] = px_total;
    v[ST_ABS_SUM] = abs_sum;
    v[ST_SQ_SUM] = sq_sum;
    v[ST_MAX_ERR] = max_err;
    v[ST_WORST_COL] = worst_col;
    v[ST_WORST_ROW] = worst_row;
    v[ST_WORST_CH] = worst_ch;
    for (int i = 0; i < 6; i++) v[ST_WORST_PIX+i] = worst_pix[i];
    for (int i = 0; i < 2; i++) begin
      v[ST_LUMA_SUM+i] = luma_sum[i];
      v[ST_LUMA_MAX+i] = luma_max[i];
      v[ST_LIT_CNT+i] = lit_cnt[i];
      v[ST_ONE_SIDED+i] = one_sided[i];
    end
    for (int i = 0; i < 8; i++) v[ST_BOX+i] = lit_box[i];
    for (int i = 0; i < 4; i++) v[ST_CSUM+i] = coord_sum[i];
    for (int i = 0; i < LIMIT_REGS; i++) v[ST_SIMILAR+i] = sim_cnt[i];
    for (int k = 0; k < NUM_STATS; k++) begin
      s.code = CODE_W'(k);
      s.value = v[k];
      s.last = (k == NUM_STATS - 1);
      report_q.insert(report_q.size(), s);
    end
    clear_image();
  endtask

  task automatic check_stat();
    stat_t e;
    if (report_q.size() == 0) begin
      $display("%0t: unexpected statistic code %0d value %0d", $time,
               stat_mon.stat_code, stat_mon.stat_value);
      fail_count_o++;
      return;
    end
    e = report_q.pop_front();
    if (stat_mon.stat_code !== e.code) begin
      $display("%0t: stat_code expected %0d actual %0d", $time, e.code, stat_mon.stat_code);
      fail_count_o++;
    end
    if (stat_mon.stat_value !== e.value) begin
      $display("%0t: stat_value (code %0d) expected %0d actual %0d", $time, e.code,
               e.value, stat_mon.stat_value);
      fail_count_o++;
    end
    if (stat_mon.last_stat !== e.last) begin
      $display("%0t: last_stat (code %0d) expected %0b actual %0b", $time, e.code,
               e.last, stat_mon.last_stat);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width = 1; lit_thr = 7; lim_used_cfg = 0;
      foreach (sim_limit[i]) sim_limit[i] = 0;
      clear_image();
      report_q.delete();
      fail_count_o = 0;
    end else begin
      if (stat_mon.valid && stat_mon.ready) check_stat();
      if (pix_mon.valid && pix_mon.ready) absorb_pixel();
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH:  img_width = cfg_data_i[WIDTH_W-1:0];
          CFG_LITTHR: lit_thr = cfg_data_i[THR_W-1:0];
          CFG_TCOUNT: lim_used_cfg = cfg_data_i[TCNT_W-1:0];
          CFG_LIM_A:  sim_limit[0] = cfg_data_i[LIMIT_W-1:0];
          CFG_LIM_B:  sim_limit[1] = cfg_data_i[LIMIT_W-1:0];
          CFG_LIM_C:  sim_limit[2] = cfg_data_i[LIMIT_W-1:0];
          CFG_LIM_D:  sim_limit[3] = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o = report_q.size();
  end
endmodule
`default_nettype wire

### sim/testbench.sv
// Testbench top: clock, reset, pixel and register stimulus, watchdog and verdict.
`default_nettype none
module testbench;
  import ids_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam logic signed [PIX_W-1:0] PMAX = 24'sh7FFFFF;
  localparam logic signed [PIX_W-1:0] PMIN = 24'sh800000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  int fail_count, pending, idle_cycles;
  int gap_pct, stall_pct;

  ids_pix_if  pix();
  ids_stat_if stat();

  image_difference_statistics i_dut (
    .clk_i, .rst_ni, .pix_i(pix), .stat_o(stat), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  ids_checker i_checker (
    .clk_i, .rst_ni, .pix_mon(pix), .stat_mon(stat), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall at the rate of the current phase
  initial begin
    stat.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      stat.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (stat.valid && stat.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Hold the sender until every report is out and the pipeline is empty
  task automatic drain();
    pix.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic setup(input logic [CFG_W-1:0] w, thr, tc, la, lb, lc, ld);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_LITTHR, thr);
    write_reg(CFG_TCOUNT, tc);
    write_reg(CFG_LIM_A, la);
    write_reg(CFG_LIM_B, lb);
    write_reg(CFG_LIM_C, lc);
    write_reg(CFG_LIM_D, ld);
  endtask

  task automatic send_pixel(input logic signed [PIX_W-1:0] rr, rg, rb, cr, cg, cb,
                            input logic lst);
    while ($urandom_range(99) < gap_pct) begin
      pix.valid = 1'b0;
      @(negedge clk_i);
    end
    pix.ref_red = rr; pix.ref_green = rg; pix.ref_blue = rb;
    pix.cand_red = cr; pix.cand_green = cg; pix.cand_blue = cb;
    pix.last_pixel = lst;
    pix.valid = 1'b1;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
  endtask

  function automatic logic signed [PIX_W-1:0] rand_chan();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom_range(1) ? PMAX : PMIN;
    if (sel <= 3) return PIX_W'($urandom);
    return PIX_W'(int'($urandom_range(262144)) - 131072);
  endfunction

  function automatic logic signed [PIX_W-1:0] near(input logic signed [PIX_W-1:0] base);
    return PIX_W'(int'(base) + int'($urandom_range(4000)) - 2000);
  endfunction

  task automatic rand_pixel(input logic lst);
    logic signed [PIX_W-1:0] rr, rg, rb;
    rr = rand_chan(); rg = rand_chan(); rb = rand_chan();
    if ($urandom_range(1))
      send_pixel(rr, rg, rb, near(rr), near(rg), near(rb), lst);
    else
      send_pixel(rr, rg, rb, rand_chan(), rand_chan(), rand_chan(), lst);
  endtask

  // Random images, mostly short; the phase may stop mid image
  task automatic rand_phase(input int n_pix, input bit hold_midway);
    int left, sent;
    sent = 0;
    while (sent < n_pix) begin
      left = ($urandom_range(9) == 0) ? $urandom_range(20, 30) : $urandom_range(1, 12);
      for (int i = 0; i < left && sent < n_pix; i++) begin
        rand_pixel(i == left - 1);
        sent++;
        if (hold_midway && sent == n_pix / 2) drain();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    pix.valid = 1'b0; pix.last_pixel = 1'b0;
    pix.ref_red = '0; pix.ref_green = '0; pix.ref_blue = '0;
    pix.cand_red = '0; pix.cand_green = '0; pix.cand_blue = '0;
    gap_pct = 0; stall_pct = 0; idle_cycles = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    setup(3, 7, 4, 0, 65536, 300000, 67108863);
    // all-zero image: empty lit mask, no worst update, zero bound hit
    send_pixel(0, 0, 0, 0, 0, 0, 1'b1);
    // extremes both ways, equal errors must not move the worst entry
    send_pixel(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1'b0);
    send_pixel(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 1'b0);
    send_pixel(0, 0, 0, 5, 5, -5, 1'b0);
    send_pixel(65536, 65536, 65536, 65536, 65536, 65536, 1'b1);
    // negative luma: maxima report zero
    send_pixel(-65536, -1, PMIN, -100, -200, -300, 1'b0);
    send_pixel(-7, -9, -11, -70000, -8, 0, 1'b1);
    // tie across channels: red wins, then green strictly larger
    send_pixel(0, 0, 0, -1000, 1000, 1000, 1'b0);
    send_pixel(0, 0, 0, 500, 2000, -2000, 1'b0);
    send_pixel(200000, 0, 0, 0, 0, 200000, 1'b0);
    send_pixel(0, 200000, 0, 0, 0, 0, 1'b1);
    drain();

    // no idling, zero width, thresholds count above the limit
    setup(0, 0, 7, 67108863, 0, 20000, 3000);
    rand_phase(100, 1'b1);
    drain();

    gap_pct = 75;
    setup(8191, 8388607, 0, 5000, 6000, 7000, 8000);
    rand_phase(100, 1'b0);
    drain();

    gap_pct = 0; stall_pct = 75;
    setup(5, 65536, 2, 131072, 1000, 0, 0);
    rand_phase(100, 1'b0);
    drain();

    gap_pct = 6; stall_pct = 6;
    setup(4096, 1, 3, 4000, 67108863, 2500, 1);
    rand_phase(100, 1'b0);
    rand_pixel(1'b1);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire
